// ===== rtl/brace_key_value_frame_parser_core_defines.svh =====
// Assertion helpers used by the parser controller.
// Each macro expects clk and rst_n to be visible at the point of use.
`ifndef BRACE_KEY_VALUE_FRAME_PARSER_CORE_DEFINES_SVH
`define BRACE_KEY_VALUE_FRAME_PARSER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BKVFP_ASSERT_IMPL(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BKVFP_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/bkvfp_pkg.sv =====
package bkvfp_pkg;

    // Storage depths and the cap on results emitted for one frame.
    localparam int KEY_CHARS   = 16;
    localparam int VALUE_CHARS = 47;
    localparam int RESULT_CAP  = 63;

    // Fixed field widths.
    localparam int BYTE_W        = 8;
    localparam int KIND_W        = 2;
    localparam int KEY_LIMIT_W   = 5;
    localparam int VALUE_LIMIT_W = 6;
    localparam int CFG_DATA_W    = 6;
    localparam int CFG_INDEX_W   = 1;

    // Derived widths for counts, store indexes and compares.
    localparam int KCW  = $clog2(KEY_CHARS + 1);
    localparam int VCW  = $clog2(VALUE_CHARS + 1);
    localparam int KIW  = (KEY_CHARS > 1) ? $clog2(KEY_CHARS) : 1;
    localparam int VIW  = (VALUE_CHARS > 1) ? $clog2(VALUE_CHARS) : 1;
    localparam int IDXW = (KIW > VIW) ? KIW : VIW;
    localparam int CW   = (KCW > VCW) ? KCW : VCW;
    localparam int RES_CW = $clog2(RESULT_CAP + 1);
    localparam int KEY_CMP_W = (KCW > KEY_LIMIT_W) ? KCW : KEY_LIMIT_W;
    localparam int VAL_CMP_W = (VCW > VALUE_LIMIT_W) ? VCW : VALUE_LIMIT_W;

    // Configuration register indexes and reset values.
    localparam logic [CFG_INDEX_W-1:0]   CFG_KEY_LIMIT     = 1'b0;
    localparam logic [CFG_INDEX_W-1:0]   CFG_VALUE_LIMIT   = 1'b1;
    localparam logic [KEY_LIMIT_W-1:0]   KEY_LIMIT_RESET   = 5'd7;
    localparam logic [VALUE_LIMIT_W-1:0] VALUE_LIMIT_RESET = 6'd47;

    // Result kinds.
    localparam logic [KIND_W-1:0] KIND_KEY   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_VALUE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_END   = 2'd2;

    // Delimiter characters.
    localparam logic [BYTE_W-1:0] CH_OPEN  = 8'h7B;
    localparam logic [BYTE_W-1:0] CH_CLOSE = 8'h7D;
    localparam logic [BYTE_W-1:0] CH_SEMI  = 8'h3B;
    localparam logic [BYTE_W-1:0] CH_BANG  = 8'h21;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic              clr_key;
        logic              clr_val;
        logic              keep_key;
        logic              keep_val;
        logic [BYTE_W-1:0] ch;
        logic              rd_en;
        logic              rd_val;
        logic [IDXW-1:0]   rd_idx;
        logic              out_load;
        logic              out_end;
        logic [KIND_W-1:0] out_kind;
        logic              out_last;
    } bkvfp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [KCW-1:0] key_count;
        logic [VCW-1:0] value_count;
        logic           out_free;
    } bkvfp_status_t;

    // HT, LF, VT, FF, CR and space.
    function automatic logic is_blank(input logic [BYTE_W-1:0] c);
        return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
    endfunction

    // Letters, digits, blanks, NUL and the accepted punctuation.
    function automatic logic is_string_char(input logic [BYTE_W-1:0] c);
        logic hit;
        hit = 1'b0;
        if ((c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A)
            || (c >= 8'h30 && c <= 8'h39))
        begin
            hit = 1'b1;
        end
        else if (c == 8'h00 || is_blank(c))
        begin
            hit = 1'b1;
        end
        else
        begin
            // _ - ! @ # $ % ^ & * ( ) = + : < > , . / ? \ " '
            case (c)
                8'h5F, 8'h2D, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E,
                8'h26, 8'h2A, 8'h28, 8'h29, 8'h3D, 8'h2B, 8'h3A, 8'h3C,
                8'h3E, 8'h2C, 8'h2E, 8'h2F, 8'h3F, 8'h5C, 8'h22, 8'h27: hit = 1'b1;
                default: hit = 1'b0;
            endcase
        end
        return hit;
    endfunction

endpackage

// ===== rtl/brace_key_value_frame_parser_core.sv =====
// Brace key/value frame parser. Takes one received byte (or an end-of-stream
// mark) per input beat, tokenizes it and, on each complete
// "{{ key ; value }}" frame, sends the stored key characters (kind 0) and then
// the value characters (kind 1), with last set on the final one. A frame
// holds at most 16 key and 47 value characters, further cut to the
// key_limit and value_limit registers, written through cfg_we, cfg_index and
// cfg_data only while the block is idle, a rule for the user that the block
// does not enforce. An end-of-stream beat, and every beat after it, answers
// with a single end result (kind 2, char 0, last 1). A byte that does not
// close a frame leaves input ready, so bytes can stream in back to back.
// The byte that closes a frame pauses input while the frame is sent; each
// character passes PH_READ, the registered read of the key and value stores,
// then PH_LOAD, which waits on output stalls. No clearing pass follows reset.
module brace_key_value_frame_parser_core
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [bkvfp_pkg::BYTE_W-1:0]         rx_byte,
    input  logic                                 end_of_stream,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [bkvfp_pkg::KIND_W-1:0]         kind,
    output logic [bkvfp_pkg::BYTE_W-1:0]         char_out,
    output logic                                 last,
    input  logic                                 cfg_we,
    input  logic [bkvfp_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [bkvfp_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import bkvfp_pkg::*;

    bkvfp_cmd_t    cmd;
    bkvfp_status_t status;

    // Tokenizer, frame tracking and replay sequencing.
    bkvfp_ctrl u_ctrl
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .rx_byte       (rx_byte),
        .end_of_stream (end_of_stream),
        .cmd           (cmd),
        .status        (status)
    );

    // Character stores, limits and the output register.
    bkvfp_datapath u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .kind      (kind),
        .char_out  (char_out),
        .last      (last)
    );

endmodule

// ===== rtl/bkvfp_datapath.sv =====
module bkvfp_datapath
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [bkvfp_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [bkvfp_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  bkvfp_pkg::bkvfp_cmd_t                cmd,
    output bkvfp_pkg::bkvfp_status_t             status,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [bkvfp_pkg::KIND_W-1:0]         kind,
    output logic [bkvfp_pkg::BYTE_W-1:0]         char_out,
    output logic                                 last
);
    import bkvfp_pkg::*;

    logic [KEY_LIMIT_W-1:0]   key_limit_reg;
    logic [VALUE_LIMIT_W-1:0] value_limit_reg;
    logic [KCW-1:0]           key_count_reg;
    logic [KCW-1:0]           key_count_next;
    logic [VCW-1:0]           value_count_reg;
    logic [VCW-1:0]           value_count_next;
    logic                     out_valid_reg;
    logic                     out_valid_next;
    logic [KIND_W-1:0]        kind_reg;
    logic [BYTE_W-1:0]        char_reg;
    logic                     last_reg;
    logic [BYTE_W-1:0]        key_rd_reg;
    logic [BYTE_W-1:0]        val_rd_reg;
    logic                     rd_sel_reg;

    logic [BYTE_W-1:0] key_mem [KEY_CHARS];
    logic [BYTE_W-1:0] val_mem [VALUE_CHARS];

    logic [KCW-1:0] eff_k;
    logic [VCW-1:0] eff_v;
    logic           k_write;
    logic           v_write;

    // A new token restarts its store; a kept character goes in only while
    // the count is below both the configured limit and the store depth.
    always_comb
    begin
        eff_k   = cmd.clr_key ? '0 : key_count_reg;
        eff_v   = cmd.clr_val ? '0 : value_count_reg;
        k_write = cmd.keep_key
                  && (KEY_CMP_W'(eff_k) < KEY_CMP_W'(key_limit_reg))
                  && (eff_k < KCW'(KEY_CHARS));
        v_write = cmd.keep_val
                  && (VAL_CMP_W'(eff_v) < VAL_CMP_W'(value_limit_reg))
                  && (eff_v < VCW'(VALUE_CHARS));
        key_count_next   = k_write ? eff_k + KCW'(1) : eff_k;
        value_count_next = v_write ? eff_v + VCW'(1) : eff_v;
    end

    // The output register frees up when its beat is taken.
    always_comb
    begin
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control registers and configuration.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_limit_reg   <= KEY_LIMIT_RESET;
            value_limit_reg <= VALUE_LIMIT_RESET;
            key_count_reg   <= KCW'(1);
            value_count_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_KEY_LIMIT:   key_limit_reg   <= cfg_data[KEY_LIMIT_W-1:0];
                    CFG_VALUE_LIMIT: value_limit_reg <= cfg_data[VALUE_LIMIT_W-1:0];
                    default:         ;
                endcase
            end
            key_count_reg   <= key_count_next;
            value_count_reg <= value_count_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Key and value stores, one write and one registered read each.
    always_ff @(posedge clk)
    begin
        if (k_write)
        begin
            key_mem[eff_k[KIW-1:0]] <= cmd.ch;
        end
        if (cmd.rd_en)
        begin
            key_rd_reg <= key_mem[cmd.rd_idx[KIW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (v_write)
        begin
            val_mem[eff_v[VIW-1:0]] <= cmd.ch;
        end
        if (cmd.rd_en)
        begin
            val_rd_reg <= val_mem[cmd.rd_idx[VIW-1:0]];
        end
    end

    // Output payload.
    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
        begin
            rd_sel_reg <= cmd.rd_val;
        end
        if (cmd.out_load)
        begin
            kind_reg <= cmd.out_kind;
            last_reg <= cmd.out_last;
            if (cmd.out_end)
            begin
                char_reg <= '0;
            end
            else
            begin
                char_reg <= rd_sel_reg ? val_rd_reg : key_rd_reg;
            end
        end
    end

    assign status.key_count   = key_count_reg;
    assign status.value_count = value_count_reg;
    assign status.out_free    = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign kind      = kind_reg;
    assign char_out  = char_reg;
    assign last      = last_reg;

endmodule

// ===== rtl/bkvfp_ctrl.sv =====
`include "brace_key_value_frame_parser_core_defines.svh"

module bkvfp_ctrl
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [bkvfp_pkg::BYTE_W-1:0]  rx_byte,
    input  logic                          end_of_stream,
    output bkvfp_pkg::bkvfp_cmd_t         cmd,
    input  bkvfp_pkg::bkvfp_status_t      status
);
    import bkvfp_pkg::*;

    typedef enum logic [2:0] {
        TM_START,
        TM_STRING,
        TM_OPEN1,
        TM_CLOSE1,
        TM_SKIP
    } token_mode_t;

    typedef enum logic [2:0] {
        FM_SEEK,
        FM_KEY,
        FM_SEMI,
        FM_VALUE,
        FM_CLOSE
    } frame_mode_t;

    typedef enum logic [2:0] {
        TK_NONE,
        TK_OPEN,
        TK_CLOSE,
        TK_SEMI,
        TK_STRING,
        TK_OTHER
    } token_t;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_READ,
        PH_LOAD
    } phase_t;

    token_mode_t       tm_reg;
    token_mode_t       tm_next;
    frame_mode_t       fm_reg;
    frame_mode_t       fm_next;
    frame_mode_t       fm_mid;
    phase_t            phase_reg;
    phase_t            phase_next;
    logic              ended_reg;
    logic              ended_next;
    logic              sel_reg;
    logic              sel_next;
    logic [IDXW-1:0]   idx_reg;
    logic [IDXW-1:0]   idx_next;
    logic [RES_CW-1:0] res_reg;
    logic [RES_CW-1:0] res_next;
    token_t            tok1;
    token_t            tok2;
    logic              again;
    logic              done;
    logic              accept;
    logic [CW-1:0]     idx1;
    logic              cap_hit;

    // Frame parser step for one complete token.
    function automatic frame_mode_t take_token(input frame_mode_t fm, input token_t tok);
        frame_mode_t nm;
        nm = FM_SEEK;
        case (fm)
            FM_SEEK:  nm = (tok == TK_OPEN)   ? FM_KEY   : FM_SEEK;
            FM_KEY:   nm = (tok == TK_STRING) ? FM_SEMI  : FM_SEEK;
            FM_SEMI:  nm = (tok == TK_SEMI)   ? FM_VALUE : FM_SEEK;
            FM_VALUE: nm = (tok == TK_STRING) ? FM_CLOSE : FM_SEEK;
            default:  nm = FM_SEEK;
        endcase
        return nm;
    endfunction

    // A byte can only be taken once the previous frame is out; an end beat
    // also needs the output register.
    assign in_ready = (phase_reg == PH_IDLE)
                      && (status.out_free || !(ended_reg || end_of_stream));
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        tm_next    = tm_reg;
        fm_next    = fm_reg;
        fm_mid     = fm_reg;
        phase_next = phase_reg;
        ended_next = ended_reg;
        sel_next   = sel_reg;
        idx_next   = idx_reg;
        res_next   = res_reg;
        cmd        = '0;
        tok1       = TK_NONE;
        tok2       = TK_NONE;
        again      = 1'b0;
        done       = 1'b0;
        idx1       = CW'(idx_reg) + CW'(1);
        cap_hit    = (res_reg == RES_CW'(RESULT_CAP - 1));

        case (phase_reg)
            PH_IDLE:
            begin
                if (accept && (ended_reg || end_of_stream))
                begin
                    // End of stream is sticky and answers every later beat.
                    ended_next   = 1'b1;
                    cmd.out_load = 1'b1;
                    cmd.out_end  = 1'b1;
                    cmd.out_kind = KIND_END;
                    cmd.out_last = 1'b1;
                end
                else if (accept)
                begin
                    // Token in progress.
                    case (tm_reg)
                        TM_STRING:
                        begin
                            if (is_string_char(rx_byte))
                            begin
                                cmd.keep_key = (fm_reg == FM_KEY);
                                cmd.keep_val = (fm_reg == FM_VALUE);
                                cmd.ch       = rx_byte;
                            end
                            else
                            begin
                                tok1  = TK_STRING;
                                again = 1'b1;
                            end
                        end
                        TM_OPEN1:
                        begin
                            tm_next = TM_START;
                            if (rx_byte == CH_OPEN)
                            begin
                                tok1 = TK_OPEN;
                            end
                            else if (rx_byte == CH_CLOSE)
                            begin
                                tm_next = TM_CLOSE1;
                            end
                            else
                            begin
                                tok1 = TK_OTHER;
                            end
                        end
                        TM_CLOSE1:
                        begin
                            tm_next = TM_START;
                            if (rx_byte == CH_CLOSE)
                            begin
                                tok1    = TK_CLOSE;
                                tm_next = TM_SKIP;
                            end
                            else
                            begin
                                tok1 = TK_OTHER;
                            end
                        end
                        TM_SKIP:
                        begin
                            // The byte after a close is dropped and a string
                            // holding a bang begins.
                            tm_next      = TM_STRING;
                            cmd.clr_key  = (fm_reg == FM_KEY);
                            cmd.clr_val  = (fm_reg == FM_VALUE);
                            cmd.keep_key = (fm_reg == FM_KEY);
                            cmd.keep_val = (fm_reg == FM_VALUE);
                            cmd.ch       = CH_BANG;
                        end
                        default:
                        begin
                            again = 1'b1;
                        end
                    endcase

                    if (tok1 != TK_NONE)
                    begin
                        fm_mid = take_token(fm_reg, tok1);
                    end
                    done    = (tok1 == TK_CLOSE) && (fm_reg == FM_CLOSE);
                    fm_next = fm_mid;

                    // The byte also starts a new token.
                    if (again)
                    begin
                        tm_next = TM_START;
                        if (is_blank(rx_byte))
                        begin
                            tok2 = TK_NONE;
                        end
                        else if (is_string_char(rx_byte))
                        begin
                            tm_next      = TM_STRING;
                            cmd.clr_key  = (fm_mid == FM_KEY);
                            cmd.clr_val  = (fm_mid == FM_VALUE);
                            cmd.keep_key = (fm_mid == FM_KEY);
                            cmd.keep_val = (fm_mid == FM_VALUE);
                            cmd.ch       = rx_byte;
                        end
                        else if (rx_byte == CH_SEMI)
                        begin
                            tok2 = TK_SEMI;
                        end
                        else if (rx_byte == CH_OPEN)
                        begin
                            tm_next = TM_OPEN1;
                        end
                        else if (rx_byte == CH_CLOSE)
                        begin
                            tm_next = TM_CLOSE1;
                        end
                        else
                        begin
                            tok2 = TK_OTHER;
                        end
                        if (tok2 != TK_NONE)
                        begin
                            fm_next = take_token(fm_mid, tok2);
                        end
                    end

                    // A complete frame starts the replay of key then value.
                    if (done)
                    begin
                        idx_next = '0;
                        res_next = '0;
                        if (status.key_count != '0)
                        begin
                            phase_next = PH_READ;
                            sel_next   = 1'b0;
                        end
                        else if (status.value_count != '0)
                        begin
                            phase_next = PH_READ;
                            sel_next   = 1'b1;
                        end
                    end
                end
            end
            PH_READ:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_val = sel_reg;
                cmd.rd_idx = idx_reg;
                phase_next = PH_LOAD;
            end
            PH_LOAD:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_kind = sel_reg ? KIND_VALUE : KIND_KEY;
                    res_next     = res_reg + RES_CW'(1);
                    phase_next   = PH_IDLE;
                    cmd.out_last = 1'b1;
                    if (!sel_reg && !cap_hit && (idx1 < CW'(status.key_count)))
                    begin
                        phase_next   = PH_READ;
                        idx_next     = IDXW'(idx1);
                        cmd.out_last = 1'b0;
                    end
                    else if (!sel_reg && !cap_hit && (status.value_count != '0))
                    begin
                        phase_next   = PH_READ;
                        sel_next     = 1'b1;
                        idx_next     = '0;
                        cmd.out_last = 1'b0;
                    end
                    else if (sel_reg && !cap_hit && (idx1 < CW'(status.value_count)))
                    begin
                        phase_next   = PH_READ;
                        idx_next     = IDXW'(idx1);
                        cmd.out_last = 1'b0;
                    end
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    // State and sequencing registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tm_reg    <= TM_STRING;
            fm_reg    <= FM_SEEK;
            phase_reg <= PH_IDLE;
            ended_reg <= 1'b0;
            sel_reg   <= 1'b0;
            idx_reg   <= '0;
            res_reg   <= '0;
        end
        else
        begin
            tm_reg    <= tm_next;
            fm_reg    <= fm_next;
            phase_reg <= phase_next;
            ended_reg <= ended_next;
            sel_reg   <= sel_next;
            idx_reg   <= idx_next;
            res_reg   <= res_next;
        end
    end

    // Once ended, the stream never resumes.
    `BKVFP_ASSERT_NEXT(a_ended_sticky, ended_reg, ended_reg, "end of stream flag dropped")

    // A key beat is only loaded from a written key position.
    `BKVFP_ASSERT_IMPL(a_key_idx_in_range, (phase_reg == PH_LOAD) && !sel_reg, CW'(idx_reg) < CW'(status.key_count), "key index beyond key count")

    // A value beat is only loaded from a written value position.
    `BKVFP_ASSERT_IMPL(a_val_idx_in_range, (phase_reg == PH_LOAD) && sel_reg, CW'(idx_reg) < CW'(status.value_count), "value index beyond value count")

    // After the end mark only end beats go out.
    `BKVFP_ASSERT_IMPL(a_no_chars_after_end, ended_reg && cmd.out_load, cmd.out_end, "character beat after end of stream")

endmodule
